// ----- design/ptau_pkg.sv -----
package ptau_pkg;

    // Operation codes carried on the input tuser.
    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_SUB   = 2'd1,
        OP_HALVE = 2'd2,
        OP_CONV  = 2'd3
    } op_t;

    // Field widths of the time format.
    localparam int SEC_W  = 32;
    localparam int NS_W   = 31;
    localparam int CORR_W = 64;

    // The correction value counts units of 2^-16 ns.
    localparam int CORR_FRAC_BITS = 16;
    localparam int CORR_NS_W      = CORR_W - CORR_FRAC_BITS;

    // Seconds from a correction never exceed 19 bits.
    localparam int CONV_SEC_W = 19;

    // Nanosecond constants, signed for the add, subtract and halve paths.
    localparam logic signed [31:0] NS_PER_SEC  = 32'sd1000000000;
    localparam logic signed [31:0] TWO_SEC_NS  = 32'sd2000000000;
    localparam logic signed [31:0] HALF_SEC_NS = 32'sd500000000;

    // Unsigned one second for the correction path.
    localparam logic [29:0] NS_PER_SEC_U = 30'd1000000000;

    // Reciprocal floor(2^52 / 1e9). Applied to the nanosecond count shifted
    // right by 20, the product shifted right by 32 gives the seconds, at most
    // one too small.
    localparam int          RECIP_SHIFT = 20;
    localparam int          RECIP_W     = 23;
    localparam logic [22:0] RECIP_NS    = 23'd4503599;
    localparam int          PROD_W      = CORR_NS_W - RECIP_SHIFT + RECIP_W;

endpackage

// ----- design/ptp_time_arithmetic_unit.sv -----
// PTP time arithmetic unit.
//
// Each input transaction on the s_ channel carries one request: the operation
// code on s_tuser and the operands on s_tdata. The block returns exactly one
// result transaction on the m_ channel for every request, in request order,
// holding signed seconds and nanoseconds.
//
// The datapath is a five-register pipeline: input register, three working
// stages (operand sums or correction magnitude, reciprocal multiply and
// whole-second extraction, remainder and second carry) and the output
// register. One request can be accepted every cycle while the receiver does not
// hold the pipeline.
//
// When the receiver holds m_tready low while a result is waiting, the whole
// pipeline holds and s_tready goes low in the same cycle; it rises again as
// soon as the waiting result is taken. Nothing is lost or repeated.
//
// Reset (aresetn low at a clock edge) clears all stage valid flags, so the
// pipeline comes out empty. The block keeps no other state.
module ptp_time_arithmetic_unit (
    input  logic         aclk,
    input  logic         aresetn,

    // Request channel.
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata fields from bit 0: x_seconds[31:0], x_nanoseconds[62:32],
    // y_seconds[94:63], y_nanoseconds[125:95], correction[189:126], zero pad.
    input  logic [191:0] s_tdata,
    // tuser fields from bit 0: req_type[1:0].
    input  logic [1:0]   s_tuser,

    // Result channel.
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata fields from bit 0: res_seconds[31:0], res_nanoseconds[62:32],
    // zero pad.
    output logic [63:0]  m_tdata
);

    // Pipeline advance: every stage moves when the output register is empty or its result is taken.
    logic adv;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    // ------------------------------------------------------------------
    // Stage A: input register.
    // ------------------------------------------------------------------
    logic                     a_valid_reg;
    ptau_pkg::op_t            a_op_reg;
    logic signed [31:0]       a_xs_reg;
    logic signed [30:0]       a_xn_reg;
    logic signed [31:0]       a_ys_reg;
    logic signed [30:0]       a_yn_reg;
    logic [63:0]              a_corr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_op_reg   <= ptau_pkg::op_t'(s_tuser);
            a_xs_reg   <= s_tdata[31:0];
            a_xn_reg   <= s_tdata[62:32];
            a_ys_reg   <= s_tdata[94:63];
            a_yn_reg   <= s_tdata[125:95];
            a_corr_reg <= s_tdata[189:126];
        end
    end

    // ------------------------------------------------------------------
    // Stage B: raw sums, the halved value and the correction magnitude.
    // ------------------------------------------------------------------
    logic signed [31:0] b_sec_next;
    logic signed [31:0] b_ns_next;
    logic signed [30:0] xn_half;
    logic signed [31:0] xs_half;
    logic signed [31:0] xn_wide;
    logic signed [31:0] yn_wide;
    logic [63:0]        corr_mag;

    logic               b_valid_reg;
    ptau_pkg::op_t      b_op_reg;
    logic signed [31:0] b_sec_reg;
    logic signed [31:0] b_ns_reg;
    logic               b_neg_reg;
    logic [47:0]        b_q_reg;

    always_comb begin
        xn_wide  = {a_xn_reg[30], a_xn_reg};
        yn_wide  = {a_yn_reg[30], a_yn_reg};
        // Halving truncates toward zero: negative values are bumped before the arithmetic shift.
        xn_half  = (a_xn_reg + $signed({30'd0, a_xn_reg[30]})) >>> 1;
        xs_half  = (a_xs_reg + $signed({31'd0, a_xs_reg[31]})) >>> 1;
        corr_mag = a_corr_reg[63] ? (64'd0 - a_corr_reg) : a_corr_reg;

        b_sec_next = '0;
        b_ns_next  = '0;
        case (a_op_reg)
            ptau_pkg::OP_ADD: begin
                b_sec_next = a_xs_reg + a_ys_reg;
                b_ns_next  = xn_wide + yn_wide;
            end
            ptau_pkg::OP_SUB: begin
                b_sec_next = a_xs_reg - a_ys_reg;
                b_ns_next  = xn_wide - yn_wide;
            end
            ptau_pkg::OP_HALVE: begin
                // An odd second leaves half a second for the nanoseconds.
                b_sec_next = xs_half;
                b_ns_next  = {xn_half[30], xn_half};
                if (a_xs_reg[0]) begin
                    if (a_xs_reg[31]) begin
                        b_ns_next = {xn_half[30], xn_half} - ptau_pkg::HALF_SEC_NS;
                    end else begin
                        b_ns_next = {xn_half[30], xn_half} + ptau_pkg::HALF_SEC_NS;
                    end
                end
            end
            default: begin
                b_sec_next = '0;
                b_ns_next  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_op_reg  <= a_op_reg;
            b_sec_reg <= b_sec_next;
            b_ns_reg  <= b_ns_next;
            b_neg_reg <= a_corr_reg[63];
            b_q_reg   <= corr_mag[63:ptau_pkg::CORR_FRAC_BITS];
        end
    end

    // ------------------------------------------------------------------
    // Stage C: whole seconds out of the nanosecond sum, reciprocal product.
    // ------------------------------------------------------------------
    logic signed [2:0]  c_qs_next;
    logic signed [31:0] c_ns_full;

    logic               c_valid_reg;
    ptau_pkg::op_t      c_op_reg;
    logic signed [31:0] c_sec_reg;
    logic signed [30:0] c_ns_reg;
    logic signed [2:0]  c_qs_reg;
    logic               c_neg_reg;
    logic [47:0]        c_q_reg;
    logic [50:0]        c_prod_reg;

    // The sum of two 31-bit values lies within two and a fraction seconds.
    // Only add and subtract carry whole seconds; a halved value stays as it is.
    always_comb begin
        c_qs_next = 3'sd0;
        c_ns_full = b_ns_reg;
        if (b_op_reg == ptau_pkg::OP_ADD || b_op_reg == ptau_pkg::OP_SUB) begin
            if (b_ns_reg >= ptau_pkg::TWO_SEC_NS) begin
                c_qs_next = 3'sd2;
                c_ns_full = b_ns_reg - ptau_pkg::TWO_SEC_NS;
            end else if (b_ns_reg >= ptau_pkg::NS_PER_SEC) begin
                c_qs_next = 3'sd1;
                c_ns_full = b_ns_reg - ptau_pkg::NS_PER_SEC;
            end else if (b_ns_reg <= -ptau_pkg::TWO_SEC_NS) begin
                c_qs_next = -3'sd2;
                c_ns_full = b_ns_reg + ptau_pkg::TWO_SEC_NS;
            end else if (b_ns_reg <= -ptau_pkg::NS_PER_SEC) begin
                c_qs_next = -3'sd1;
                c_ns_full = b_ns_reg + ptau_pkg::NS_PER_SEC;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_op_reg   <= b_op_reg;
            c_sec_reg  <= b_sec_reg;
            c_ns_reg   <= c_ns_full[30:0];
            c_qs_reg   <= c_qs_next;
            c_neg_reg  <= b_neg_reg;
            c_q_reg    <= b_q_reg;
            c_prod_reg <= ptau_pkg::PROD_W'(b_q_reg[47:ptau_pkg::RECIP_SHIFT])
                          * ptau_pkg::PROD_W'(ptau_pkg::RECIP_NS);
        end
    end

    // ------------------------------------------------------------------
    // Stage D: carry the whole seconds, estimated quotient and remainder.
    // ------------------------------------------------------------------
    logic [18:0]        c_est;
    logic [47:0]        c_rem_full;

    logic               d_valid_reg;
    ptau_pkg::op_t      d_op_reg;
    logic signed [31:0] d_sec_reg;
    logic signed [30:0] d_ns_reg;
    logic               d_neg_reg;
    logic [18:0]        d_est_reg;
    logic [30:0]        d_rem_reg;

    // The estimate never exceeds the true quotient, so the remainder stays
    // below two seconds.
    assign c_est      = c_prod_reg[50:32];
    assign c_rem_full = c_q_reg - (48'(c_est) * 48'(ptau_pkg::NS_PER_SEC_U));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (adv) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_op_reg  <= c_op_reg;
            d_sec_reg <= c_sec_reg + {{29{c_qs_reg[2]}}, c_qs_reg};
            d_ns_reg  <= c_ns_reg;
            d_neg_reg <= c_neg_reg;
            d_est_reg <= c_est;
            d_rem_reg <= c_rem_full[30:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage E: sign agreement, quotient correction, output register.
    // ------------------------------------------------------------------
    logic signed [31:0] e_sec_next;
    logic signed [30:0] e_ns_next;
    logic               rem_ge;
    logic [29:0]        rem_fix;
    logic [18:0]        sec_fix;
    logic [31:0]        conv_sec;
    logic [30:0]        conv_ns;

    logic               m_valid_reg;
    logic signed [31:0] m_sec_reg;
    logic signed [30:0] m_ns_reg;

    always_comb begin
        rem_ge   = d_rem_reg >= 31'(ptau_pkg::NS_PER_SEC_U);
        rem_fix  = rem_ge ? 30'(d_rem_reg - 31'(ptau_pkg::NS_PER_SEC_U))
                          : d_rem_reg[29:0];
        sec_fix  = d_est_reg + {18'd0, rem_ge};
        conv_sec = d_neg_reg ? (32'd0 - 32'(sec_fix)) : 32'(sec_fix);
        conv_ns  = d_neg_reg ? (31'd0 - 31'(rem_fix)) : 31'(rem_fix);

        e_sec_next = d_sec_reg;
        e_ns_next  = d_ns_reg;
        case (d_op_reg) inside
            ptau_pkg::OP_ADD, ptau_pkg::OP_SUB: begin
                // Borrow or return one second so that the signs agree.
                if (d_sec_reg > 0 && d_ns_reg < 0) begin
                    e_sec_next = d_sec_reg - 32'sd1;
                    e_ns_next  = d_ns_reg + ptau_pkg::NS_PER_SEC[30:0];
                end else if (d_sec_reg < 0 && d_ns_reg > 0) begin
                    e_sec_next = d_sec_reg + 32'sd1;
                    e_ns_next  = d_ns_reg - ptau_pkg::NS_PER_SEC[30:0];
                end
            end
            ptau_pkg::OP_HALVE: begin
                e_sec_next = d_sec_reg;
                e_ns_next  = d_ns_reg;
            end
            default: begin
                e_sec_next = conv_sec;
                e_ns_next  = conv_ns;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_sec_reg <= e_sec_next;
            m_ns_reg  <= e_ns_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_ns_reg, m_sec_reg};

endmodule
